// File: rtl/tacc_pkg.sv
// ----------------------------------------------------------------------------
// tacc_pkg: shared types for the touch auto-repeat clock controller
// Controller state codes, configuration and counter bundles, result record.
// ----------------------------------------------------------------------------
package tacc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SETTLE_TICKS = 2'd0;
  localparam logic [1:0] CFG_AUTO_DELAY   = 2'd1;
  localparam logic [1:0] CFG_REPEAT_TICKS = 2'd2;
  localparam logic [1:0] CFG_TICKS_PER_S  = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // configuration reset values
  localparam logic [7:0]  SettleReset = 8'd1;
  localparam logic [7:0]  AutoReset   = 8'd10;
  localparam logic [7:0]  RepeatReset = 8'd2;
  localparam logic [15:0] TpsReset    = 16'd20;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_NEVER    = 3'd1,
    ST_WAIT     = 3'd2,
    ST_SETTLE   = 3'd3,
    ST_AUTO     = 3'd4,
    ST_RATE_RUN = 3'd5,
    ST_RATE_EXP = 3'd6,
    ST_ADD_SEC  = 3'd7
  } ctrl_state_e;

  // configuration registers
  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [7:0]  auto_delay_ticks;
    logic [7:0]  repeat_period_ticks;
    logic [15:0] ticks_per_second;
  } cfg_t;

  // tick counters
  typedef struct packed {
    logic [7:0]  settle;
    logic [7:0]  hold;
    logic [7:0]  repeat_cnt;
    logic [15:0] second;
  } cnt_t;

  // one result transaction
  typedef struct packed {
    logic        inc_dec_pulse;
    logic        advance_second;
    logic        clear_touch;
    ctrl_state_e ctrl_state;
  } res_t;

endpackage

// File: rtl/touch_autorepeat_clock_controller.sv
// ----------------------------------------------------------------------------
// touch_autorepeat_clock_controller: touch-driven clock set controller
// Eight-state controller with settle, auto-delay, repeat and second counters.
// ----------------------------------------------------------------------------
// One tick transaction is accepted every cycle while input ready is high;
// its result is registered in the output buffer. State and counters update
// in the cycle of acceptance through a single pass of decode, equality
// compares and increments, and a two-entry output buffer (output register plus
// skid entry) keeps ticks flowing while a result waits, so input ready drops
// only when both entries hold untaken results. Configuration writes take
// effect at the next clock edge and should be made while no tick is in flight.
module touch_autorepeat_clock_controller import tacc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                touched_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                inc_dec_pulse_o,
  output logic                advance_second_o,
  output logic                clear_touch_o,
  output logic [2:0]          ctrl_state_o
);

  cfg_t        cfg_q, cfg_d;
  ctrl_state_e state_q, state_d;
  cnt_t        cnt_q, cnt_d;
  res_t        res, res_out;
  logic        full, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETTLE_TICKS: cfg_d.settle_ticks        = cfg_data_i[7:0];
        CFG_AUTO_DELAY:   cfg_d.auto_delay_ticks    = cfg_data_i[7:0];
        CFG_REPEAT_TICKS: cfg_d.repeat_period_ticks = cfg_data_i[7:0];
        CFG_TICKS_PER_S:  cfg_d.ticks_per_second    = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks        <= SettleReset;
      cfg_q.auto_delay_ticks    <= AutoReset;
      cfg_q.repeat_period_ticks <= RepeatReset;
      cfg_q.ticks_per_second    <= TpsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // tick logic
  tacc_step u_step (
    .state_i   (state_q),
    .cnt_i     (cnt_q),
    .cfg_i     (cfg_q),
    .touched_i (touched_i),
    .state_o   (state_d),
    .cnt_o     (cnt_d),
    .res_o     (res)
  );

  // controller state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else if (accept) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // result buffering
  tacc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign inc_dec_pulse_o  = res_out.inc_dec_pulse;
  assign advance_second_o = res_out.advance_second;
  assign clear_touch_o    = res_out.clear_touch;
  assign ctrl_state_o     = res_out.ctrl_state;

  // state only moves on an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(state_q) && $stable(cnt_q)))
    else $error("controller moved without a tick");

  // init always leaves for never-touched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_INIT) |=> (state_q == ST_NEVER))
    else $error("init did not advance");

  // reaching the second limit enters add-second and clears the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_WAIT && cnt_q.second == cfg_q.ticks_per_second)
    |=> (state_q == ST_ADD_SEC && cnt_q.second == '0))
    else $error("second limit not handled");

endmodule

// File: rtl/tacc_step.sv
// ----------------------------------------------------------------------------
// tacc_step: one tick of the controller
// Transition, event flags and counter update for one sampled touch flag.
// ----------------------------------------------------------------------------
module tacc_step import tacc_pkg::*; (
  input  ctrl_state_e state_i,
  input  cnt_t        cnt_i,
  input  cfg_t        cfg_i,
  input  logic        touched_i,
  output ctrl_state_e state_o,
  output cnt_t        cnt_o,
  output res_t        res_o
);

  ctrl_state_e next_d;
  logic        pulse, clr;

  // next state
  always_comb begin
    next_d = state_i;
    case (state_i)
      ST_INIT:  next_d = ST_NEVER;
      ST_NEVER: if (touched_i) next_d = ST_WAIT;
      ST_WAIT: begin
        if (cnt_i.second == cfg_i.ticks_per_second) next_d = ST_ADD_SEC;
        else if (touched_i)                          next_d = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (cnt_i.settle == cfg_i.settle_ticks) next_d = touched_i ? ST_AUTO : ST_WAIT;
      end
      ST_AUTO: begin
        if (!touched_i)                                 next_d = ST_WAIT;
        else if (cnt_i.hold == cfg_i.auto_delay_ticks)  next_d = ST_RATE_RUN;
      end
      ST_RATE_RUN: begin
        if (!touched_i)                                       next_d = ST_WAIT;
        else if (cnt_i.repeat_cnt == cfg_i.repeat_period_ticks) next_d = ST_RATE_EXP;
      end
      ST_RATE_EXP: next_d = touched_i ? ST_RATE_RUN : ST_WAIT;
      ST_ADD_SEC:  next_d = ST_WAIT;
      default:     next_d = ST_INIT;
    endcase
  end

  // transition flags
  always_comb begin
    pulse = 1'b0;
    clr   = 1'b0;
    case (state_i)
      ST_NEVER:    clr   = (next_d == ST_WAIT);
      ST_WAIT:     clr   = (next_d == ST_SETTLE);
      ST_SETTLE:   pulse = (next_d == ST_WAIT);
      ST_AUTO:     pulse = (next_d != ST_AUTO);
      ST_RATE_EXP: pulse = (next_d == ST_RATE_RUN);
      default: begin
        pulse = 1'b0;
        clr   = 1'b0;
      end
    endcase
  end

  // action of the entered state
  always_comb begin
    cnt_o = cnt_i;
    case (next_d)
      ST_WAIT: begin
        cnt_o.settle     = '0;
        cnt_o.hold       = '0;
        cnt_o.repeat_cnt = '0;
        cnt_o.second     = cnt_i.second + 16'd1;
      end
      ST_SETTLE:   cnt_o.settle     = cnt_i.settle + 8'd1;
      ST_AUTO:     cnt_o.hold       = cnt_i.hold + 8'd1;
      ST_RATE_RUN: cnt_o.repeat_cnt = cnt_i.repeat_cnt + 8'd1;
      ST_RATE_EXP: cnt_o.repeat_cnt = '0;
      ST_ADD_SEC:  cnt_o.second     = '0;
      default:     cnt_o = cnt_i;
    endcase
  end

  assign state_o             = next_d;
  assign res_o.inc_dec_pulse  = pulse;
  assign res_o.advance_second = (next_d == ST_ADD_SEC);
  assign res_o.clear_touch    = clr;
  assign res_o.ctrl_state     = next_d;

endmodule

// File: rtl/tacc_outbuf.sv
// ----------------------------------------------------------------------------
// tacc_outbuf: two-entry result buffer
// Output register plus skid entry so a new tick is taken while a result waits.
// ----------------------------------------------------------------------------
module tacc_outbuf import tacc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t data_o
);

  logic head_vld_q, head_vld_d;
  logic skid_vld_q, skid_vld_d;
  res_t head_q, head_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = head_vld_q && out_ready_i;

  // entry movement
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        head_d     = data_i;
        head_vld_d = push_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_d     = data_i;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign data_o      = head_q;

  // skid entry only fills behind a valid head
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> head_vld_q)
    else $error("skid entry valid without head entry");

  // a held result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_vld_q && !out_ready_i) |=> (head_vld_q && $stable(head_q)))
    else $error("waiting result lost or changed");

endmodule
